### sv/jse_pkg.sv
// Types, constants and escape functions for the string byte escaper.
package jse_pkg;

    localparam int IDX_W = 3;

    localparam logic MODE_STRING  = 1'b0;
    localparam logic MODE_PERCENT = 1'b1;

    localparam logic [7:0] CH_BSL     = 8'h5c;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_A_LOW   = 8'h61;
    localparam logic [7:0] CTRL_FIRST = 8'h07;
    localparam logic [7:0] CTRL_LAST  = 8'h0d;
    localparam logic [7:0] UNI_LAST   = 8'h1f;

    localparam logic [IDX_W-1:0] LEN_ONE = 3'd1;
    localparam logic [IDX_W-1:0] LEN_TWO = 3'd2;
    localparam logic [IDX_W-1:0] LEN_UNI = 3'd6;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } jse_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end_out;
    } jse_out_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = CH_ZERO + {4'd0, nib};
        end else begin
            r = CH_A_LOW + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

    function automatic logic [7:0] ctrl_letter(input logic [7:0] b);
        logic [7:0] r;
        case (b[3:0])
            4'h7:    r = 8'h61;
            4'h8:    r = 8'h62;
            4'h9:    r = 8'h74;
            4'ha:    r = 8'h6e;
            4'hb:    r = 8'h76;
            4'hc:    r = 8'h66;
            default: r = 8'h72;
        endcase
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] run_len(input logic mode, input logic [7:0] b);
        logic [IDX_W-1:0] r;
        r = LEN_ONE;
        if (mode == MODE_STRING) begin
            if (b == CH_BSL || b == CH_QUOTE) begin
                r = LEN_TWO;
            end else if (b >= CTRL_FIRST && b <= CTRL_LAST) begin
                r = LEN_TWO;
            end else if (b != 8'd0 && b <= UNI_LAST) begin
                r = LEN_UNI;
            end
        end else if (b == CH_PERCENT) begin
            r = LEN_TWO;
        end
        return r;
    endfunction

    function automatic logic [7:0] run_byte(input logic mode, input logic [7:0] b,
                                            input logic [IDX_W-1:0] idx);
        logic [7:0] r;
        r = b;
        if (mode == MODE_STRING) begin
            if (b == CH_BSL || b == CH_QUOTE) begin
                r = (idx == '0) ? CH_BSL : b;
            end else if (b >= CTRL_FIRST && b <= CTRL_LAST) begin
                r = (idx == '0) ? CH_BSL : ctrl_letter(b);
            end else if (b != 8'd0 && b <= UNI_LAST) begin
                case (idx)
                    3'd0:    r = CH_BSL;
                    3'd1:    r = CH_U;
                    3'd2:    r = CH_ZERO;
                    3'd3:    r = CH_ZERO;
                    3'd4:    r = hex_digit(b[7:4]);
                    default: r = hex_digit(b[3:0]);
                endcase
            end
        end
        return r;
    endfunction

endpackage

### sv/json_string_byte_escaper.sv
// Top level of the string byte escaper: input hold register, run counter, output register.
//
// Takes one string byte per transfer and sends its escaped form one byte per
// transfer. A byte that passes through unchanged is sent as it is, so plain text
// flows at one byte per cycle while m_ready stays high; a byte that expands to N output
// bytes (2 for two-character escapes and percent doubling, 6 for the \u00xx form)
// holds the input while the run counter steps through the escape sequence.
// The input accepts a new byte in the same cycle that the last byte of the
// current run moves into the output register. The escape mode (mode_reg) is written
// through the cfg channel; the user must write it only while no transfer is in flight,
// as the block does not enforce this; 0 selects string escapes, 1 percent doubling.
module json_string_byte_escaper
    import jse_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  jse_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output jse_out_t m_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data
);

    logic             mode_reg;
    logic             cur_valid_reg;
    logic [7:0]       cur_byte_reg;
    logic             cur_end_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             m_valid_reg;
    jse_out_t         m_data_reg;

    logic [IDX_W-1:0] len;
    logic             emit;
    logic             last;

    assign len       = run_len(mode_reg, cur_byte_reg);
    assign emit      = cur_valid_reg && (!m_valid_reg || m_ready);
    assign last      = (idx_reg == len - LEN_ONE);
    assign s_ready   = !cur_valid_reg || (emit && last);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_STRING;
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            if (s_valid && s_ready) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (emit && last) begin
                cur_valid_reg <= 1'b0;
                idx_reg       <= '0;
            end else if (emit) begin
                idx_reg <= idx_reg + LEN_ONE;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cur_byte_reg <= s_data.in_byte;
            cur_end_reg  <= s_data.string_end;
        end
        if (emit) begin
            m_data_reg.out_byte       <= run_byte(mode_reg, cur_byte_reg, idx_reg);
            m_data_reg.run_last       <= last;
            m_data_reg.string_end_out <= last && cur_end_reg;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> idx_reg < len)
        else $error("run index past run length");

    a_end_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.string_end_out |-> m_data.run_last)
        else $error("string end flagged on non-final run byte");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg && !(emit && last) |-> !s_ready)
        else $error("input taken mid-run");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.run_last |=> m_valid)
        else $error("run broken before its last byte");
`endif

endmodule
